// ----- sv/fanlvl_pkg.sv -----
// ----------------------------------------------------------------------------
// fanlvl_pkg
// Shared widths, codes, command and status types, and the fan level table.
// ----------------------------------------------------------------------------
package fanlvl_pkg;

  localparam int TEMP_W         = 8;
  localparam int PS_W           = 2;
  localparam int CHAN_W         = 2;
  localparam int LVL_W          = 3;
  localparam int RPM_W          = 13;
  localparam int TABLE_ROWS     = 6;
  localparam int NUM_LEVELS_DEF = 6;

  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = PS_W + 1 + CHAN_W;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = CHAN_W;

  // Power state codes.
  localparam logic [PS_W-1:0] PS_RUN     = 2'd0;
  localparam logic [PS_W-1:0] PS_SUSPEND = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } fanlvl_state_t;

  typedef struct packed {
    logic load;    // capture an accepted input transfer
    logic step;    // move the level one entry
    logic commit;  // store the sample as the previous temperature
    logic emit;    // write the result register
  } fanlvl_cmd_t;

  typedef struct packed {
    logic is_run;
    logic is_susp;
    logic walk_more;
    logic out_free;
  } fanlvl_stat_t;

  // Temperature above which the level rises.
  function automatic logic signed [TEMP_W-1:0] trip_on(input logic [LVL_W-1:0] lvl);
    logic signed [TEMP_W-1:0] t;
    case (lvl)
      3'd0:    t = 8'sd43;
      3'd1:    t = 8'sd45;
      3'd2:    t = 8'sd46;
      3'd3:    t = 8'sd48;
      3'd4:    t = 8'sd50;
      3'd5:    t = 8'sd52;
      default: t = 8'sd127;
    endcase
    return t;
  endfunction

  // Temperature below which the level falls.
  function automatic logic signed [TEMP_W-1:0] trip_off(input logic [LVL_W-1:0] lvl);
    logic signed [TEMP_W-1:0] t;
    case (lvl)
      3'd0:    t = 8'sd0;
      3'd1:    t = 8'sd43;
      3'd2:    t = 8'sd44;
      3'd3:    t = 8'sd45;
      3'd4:    t = 8'sd47;
      3'd5:    t = 8'sd49;
      default: t = -8'sd128;
    endcase
    return t;
  endfunction

  function automatic logic [RPM_W-1:0] level_rpm(input logic [LVL_W-1:0] lvl,
                                                 input logic            tablet);
    logic [RPM_W-1:0] r;
    case (lvl)
      3'd1:    r = 13'd3400;
      3'd2:    r = tablet ? 13'd3700 : 13'd3800;
      3'd3:    r = tablet ? 13'd4100 : 13'd4200;
      3'd4:    r = 13'd4800;
      3'd5:    r = tablet ? 13'd5200 : 13'd5400;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/fan_level_hysteresis_table.sv -----
// ----------------------------------------------------------------------------
// fan_level_hysteresis_table
// Fan speed table with hysteresis, driven by one temperature sample per
// transfer.
// ----------------------------------------------------------------------------
// Usage: each input transfer carries a signed temperature in in_tdata and the
// power state, tablet flag and fan channel in in_tuser. When the power state
// is running, the block walks its fan level toward the sample, one level per
// cycle, and returns one result transfer with the channel, the table RPM
// (channel 0 only) and the new level. A suspended sample returns RPM 0 with
// the held level and changes nothing. Any other power state returns nothing.
// The idle state takes the sample, the walk state moves the level one entry at
// a time and then stores the sample as the previous temperature, and the emit
// state loads the output register. One sample is in work at a time;
// in_tready is high only while the sequencer waits for a sample, so the walk
// of the level table sets the rate.
// A finished result sits in the output register; if the receiver stalls, the
// next sample is still taken and walked, and it waits only to be written out.
// Reset clears the level and the previous temperature to zero and drops
// out_tvalid.
// ----------------------------------------------------------------------------
module fan_level_hysteresis_table
  import fanlvl_pkg::*;
#(
  parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] temperature
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // [1:0] power state, [2] tablet flag,
                                             // [4:3] fan channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [12:0] rpm_target, [15:13] level_out
  output logic [OUT_TUSER_W-1:0] out_tuser   // [1:0] channel_out
);

  fanlvl_cmd_t  cmd;
  fanlvl_stat_t stat;

  // The sequencer issues one command per cycle; the datapath reports back
  // whether the level still has to move and whether the output is free.
  fanlvl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fanlvl_dp #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// ----- sv/fanlvl_ctrl.sv -----
// ----------------------------------------------------------------------------
// fanlvl_ctrl
// Sequencer: accepts a sample, walks the level one entry per cycle for a running
// sample, then hands the result to the output register; an ignored power state returns to idle.
// ----------------------------------------------------------------------------
module fanlvl_ctrl
  import fanlvl_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  fanlvl_stat_t stat,
  output fanlvl_cmd_t  cmd
);

  fanlvl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (stat.is_run) begin
          if (!stat.walk_more) state_nxt = ST_EMIT;
        end else if (stat.is_susp) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_WALK: begin
        if (stat.is_run) begin
          cmd.step   = stat.walk_more;
          cmd.commit = !stat.walk_more;
        end
      end
      ST_EMIT: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// ----- sv/fanlvl_dp.sv -----
// ----------------------------------------------------------------------------
// fanlvl_dp
// Datapath: sample registers, level and previous temperature, table lookup
// and the output register.
// ----------------------------------------------------------------------------
module fanlvl_dp
  import fanlvl_pkg::*;
#(
  parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser,
  input  fanlvl_cmd_t            cmd,
  output fanlvl_stat_t           stat
);

  localparam int TopInt = ((NUM_LEVELS < TABLE_ROWS) ? NUM_LEVELS : TABLE_ROWS) - 1;
  localparam logic [LVL_W-1:0] TopLevel = LVL_W'(TopInt);

  logic signed [TEMP_W-1:0] temp_r;
  logic [PS_W-1:0]          ps_r;
  logic                     tablet_r;
  logic [CHAN_W-1:0]        chan_r;

  logic [LVL_W-1:0]         level_r, level_nxt;
  logic signed [TEMP_W-1:0] last_r, last_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [RPM_W-1:0]         out_rpm_r;
  logic [LVL_W-1:0]         out_lvl_r;
  logic [CHAN_W-1:0]        out_chan_r;

  logic go_down, go_up, more;

  // Sample registers hold payload only.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      temp_r   <= $signed(in_tdata[TEMP_W-1:0]);
      ps_r     <= in_tuser[PS_W-1:0];
      tablet_r <= in_tuser[PS_W];
      chan_r   <= in_tuser[PS_W+1 +: CHAN_W];
    end
  end

  assign go_down = (temp_r < last_r) && (level_r != '0) && (temp_r < trip_off(level_r));
  assign go_up   = (temp_r > last_r) && (level_r < TopLevel) && (temp_r > trip_on(level_r));
  assign more    = go_down || go_up;

  always_comb begin
    level_nxt = level_r;
    last_nxt  = last_r;
    if (cmd.step) begin
      level_nxt = go_down ? (level_r - 1'b1) : (level_r + 1'b1);
    end
    if (cmd.commit) begin
      last_nxt = temp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      last_r  <= '0;
    end else begin
      level_r <= level_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Only a running sample on channel 0 drives a nonzero target.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_chan_r <= chan_r;
      out_lvl_r  <= level_r;
      out_rpm_r  <= ((ps_r == PS_RUN) && (chan_r == '0)) ? level_rpm(level_r, tablet_r)
                                                         : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_lvl_r, out_rpm_r};
  assign out_tuser  = out_chan_r;

  assign stat.is_run    = (ps_r == PS_RUN);
  assign stat.is_susp   = (ps_r == PS_SUSPEND);
  assign stat.walk_more = more;
  assign stat.out_free  = !out_valid_r || out_tready;

endmodule

// ----- verif/fan_target_tracker_pkg.sv -----
// ----------------------------------------------------------------------------
// fan_target_tracker_pkg
// Tracks the fan level for the testbench and checks the fan targets that the
// block returns against the predicted ones, in the order they were caused.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fan_target_tracker_pkg;
  import fanlvl_pkg::*;

  // Power states that the block takes no action on.
  localparam logic [PS_W-1:0] PS_IGNORED    = 2'd2;
  localparam logic [PS_W-1:0] PS_IGNORED_HI = 2'd3;

  localparam int TOP_LEVEL =
    ((NUM_LEVELS_DEF < TABLE_ROWS) ? NUM_LEVELS_DEF : TABLE_ROWS) - 1;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [RPM_W-1:0]  rpm;
    logic [LVL_W-1:0]  level;
  } fan_target_t;

  class fan_target_tracker;
    logic [LVL_W-1:0]         fan_level;
    logic signed [TEMP_W-1:0] last_sample;
    fan_target_t              pending_targets[$];
    int                       mismatches;

    function new();
      fan_level   = '0;
      last_sample = '0;
      mismatches  = 0;
    endfunction

    function int rise_point(int lvl);
      case (lvl)
        0:       return 43;
        1:       return 45;
        2:       return 46;
        3:       return 48;
        4:       return 50;
        default: return 52;
      endcase
    endfunction

    function int fall_point(int lvl);
      case (lvl)
        1:       return 43;
        2:       return 44;
        3:       return 45;
        4:       return 47;
        5:       return 49;
        default: return 0;
      endcase
    endfunction

    function int table_rpm(int lvl, logic tablet);
      case (lvl)
        1:       return 3400;
        2:       return tablet ? 3700 : 3800;
        3:       return tablet ? 4100 : 4200;
        4:       return 4800;
        5:       return tablet ? 5200 : 5400;
        default: return 0;
      endcase
    endfunction

    function int pending();
      return pending_targets.size();
    endfunction

    // Called for every accepted sample; queues the target it should cause, if any.
    function void take_sample(logic signed [TEMP_W-1:0] temp, logic [PS_W-1:0] ps,
                              logic tablet, logic [CHAN_W-1:0] chan);
      fan_target_t t;
      int          rpm;
      rpm = 0;
      if (fan_level > TOP_LEVEL) fan_level = LVL_W'(TOP_LEVEL);
      if (ps == PS_RUN) begin
        if (temp < last_sample) begin
          while (fan_level > 0 && temp < fall_point(int'(fan_level))) fan_level--;
        end else if (temp > last_sample) begin
          while (fan_level < TOP_LEVEL && temp > rise_point(int'(fan_level))) fan_level++;
        end
        last_sample = temp;
        if (chan == '0) rpm = table_rpm(int'(fan_level), tablet);
      end else if (ps != PS_SUSPEND) begin
        return;
      end
      t.chan  = chan;
      t.rpm   = RPM_W'(rpm);
      t.level = fan_level;
      pending_targets.push_back(t);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    // Called for every accepted result; checks it against the oldest target.
    function void match_target(logic [CHAN_W-1:0] chan, logic [RPM_W-1:0] rpm,
                               logic [LVL_W-1:0] level);
      fan_target_t want;
      if (pending_targets.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual chan %0d rpm %0d level %0d",
                 $time, chan, rpm, level);
        mismatches++;
        return;
      end
      want = pending_targets.pop_front();
      compare_field("channel_out", 16'(want.chan), 16'(chan));
      compare_field("rpm_target", 16'(want.rpm), 16'(rpm));
      compare_field("level_out", 16'(want.level), 16'(level));
    endfunction
  endclass

endpackage

// ----- verif/fan_level_hysteresis_table_tb.sv -----
// ----------------------------------------------------------------------------
// fan_level_hysteresis_table_tb
// Drives temperature samples into the fan level table and checks every fan
// target against a cycle-free prediction of the hysteresis walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fan_level_hysteresis_table_tb;
  import fanlvl_pkg::*;
  import fan_target_tracker_pkg::*;

  localparam int RANDOM_SAMPLES = 1350;
  // Cycles with no transfer on either side before the run is declared hung.
  localparam int STALL_LIMIT    = 2000;
  // This leaves room for a late result.
  localparam int SETTLE_CYCLES  = 16;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // [7:0] temperature
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;  // [1:0] power state, [2] tablet flag,
                                            // [4:3] fan channel
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // [12:0] rpm_target, [15:13] level_out
  logic [OUT_TUSER_W-1:0] out_tuser;        // [1:0] channel_out

  // While set, neither the sender nor the receiver inserts idle cycles.
  logic              steady_flow = 1'b0;
  fan_target_tracker tracker     = new();
  int                quiet_cycles = 0;

  fan_level_hysteresis_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // The receiver stalls in roughly one cycle of five unless a steady stretch
  // is running. The ready is only driven from the clock edge.
  always @(posedge clk) begin
    out_tready <= steady_flow || ($urandom_range(0, 99) >= 19);
  end

  // Both monitors sample the values that were present before the edge, so
  // the order against the block's own flops does not matter.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      tracker.take_sample(in_tdata[TEMP_W-1:0], in_tuser[PS_W-1:0], in_tuser[PS_W],
                          in_tuser[PS_W+1 +: CHAN_W]);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.match_target(out_tuser[CHAN_W-1:0], out_tdata[RPM_W-1:0],
                           out_tdata[RPM_W +: LVL_W]);
    end
  end

  // Watchdog: any transfer on either side resets the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("fan_level_hysteresis_table_tb failed");
        $finish;
      end
    end
  end

  // Sends one sample, with random idle cycles ahead of it, and returns at the
  // edge where the transfer happened. The valid is left high so that a
  // following sample can go out back to back.
  task automatic push_sample(input logic [TEMP_W-1:0] temp, input logic [PS_W-1:0] ps,
                             input logic tablet, input logic [CHAN_W-1:0] chan);
    while (!steady_flow && $urandom_range(0, 99) < 19) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= temp;
    in_tuser  <= {chan, tablet, ps};
    do @(posedge clk); while (!in_tready);
  endtask

  // Holds the sender off until every queued target has come back.
  task automatic drain_targets();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // Random samples mostly drift around the trip points, so the level keeps
  // walking both ways; the rest cover the whole temperature range.
  task automatic random_samples();
    logic [TEMP_W-1:0] temp;
    int                drift;
    int                pick;
    logic [PS_W-1:0]   ps;
    drift = 45;
    for (int n = 0; n < RANDOM_SAMPLES; n++) begin
      if (n == 500) drain_targets();
      steady_flow = (n >= 700 && n < 900);
      if ($urandom_range(0, 99) < 78) begin
        drift = drift + $urandom_range(0, 10) - 5;
        if (drift < 25) drift = 25;
        if (drift > 70) drift = 70;
        temp = drift[TEMP_W-1:0];
      end else begin
        temp = TEMP_W'($urandom_range(0, 255));
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) ps = PS_RUN;
      else if (pick < 84) ps = PS_SUSPEND;
      else if (pick < 92) ps = PS_IGNORED;
      else ps = PS_IGNORED_HI;
      push_sample(temp, ps, 1'($urandom_range(0, 1)),
                  ($urandom_range(0, 1) == 1) ? 2'd0 : CHAN_W'($urandom_range(0, 3)));
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Unchanged temperature at reset keeps level 0.
    push_sample(8'sd0, PS_RUN, 1'b0, 2'd0);
    // One step up, then a jump to the hottest sample which stops at the top
    // level because the top entry's trip point is never consulted.
    push_sample(8'sd44, PS_RUN, 1'b0, 2'd0);
    push_sample(8'sd127, PS_RUN, 1'b0, 2'd0);
    // Suspend reports zero with the held level; the other states are dropped.
    push_sample(-8'sd128, PS_SUSPEND, 1'b1, 2'd0);
    push_sample(8'sd10, PS_IGNORED, 1'b1, 2'd3);
    push_sample(-8'sd5, PS_IGNORED_HI, 1'b0, 2'd1);
    push_sample(8'sd127, PS_RUN, 1'b1, 2'd0);
    // Channels other than zero get no RPM but still move the level.
    push_sample(8'sd126, PS_RUN, 1'b1, 2'd3);
    push_sample(8'sd48, PS_RUN, 1'b0, 2'd1);
    push_sample(8'sd48, PS_RUN, 1'b1, 2'd0);
    // Coldest sample walks all the way down; level 0 has no release point.
    push_sample(-8'sd128, PS_RUN, 1'b0, 2'd2);
    push_sample(-8'sd128, PS_RUN, 1'b1, 2'd0);
    // Rising exactly onto a trip point does not cross it.
    push_sample(8'sd46, PS_RUN, 1'b1, 2'd0);
    push_sample(8'sd44, PS_RUN, 1'b0, 2'd0);
    push_sample(8'sd43, PS_RUN, 1'b1, 2'd0);
    push_sample(8'sd50, PS_RUN, 1'b0, 2'd0);
    push_sample(8'sd51, PS_RUN, 1'b1, 2'd0);
    push_sample(8'sd53, PS_RUN, 1'b0, 2'd0);
    push_sample(8'sd42, PS_SUSPEND, 1'b0, 2'd3);
    push_sample(8'sd42, PS_RUN, 1'b1, 2'd0);

    random_samples();

    drain_targets();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("fan_level_hysteresis_table_tb passed");
    end else begin
      $display("fan_level_hysteresis_table_tb failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/fanlvl_pkg.sv
sv/fanlvl_ctrl.sv
sv/fanlvl_dp.sv
sv/fan_level_hysteresis_table.sv
verif/fan_target_tracker_pkg.sv
verif/fan_level_hysteresis_table_tb.sv
